### rtl/mwfe_pkg.sv
// Shared constants, types and helpers of the motion window feature extractor.
package mwfe_pkg;

    localparam int WINDOW = 20;
    localparam int CNT_W  = (WINDOW > 2) ? $clog2(WINDOW) : 1;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 20;
    localparam int LBL_W  = 2;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam int ABS_W  = IN_W + 1;
    localparam int MAG_W  = 16;
    localparam int SUM_W  = 24;
    localparam int SQS_W  = 40;
    localparam int TSUM_W = 25;
    localparam int PROD_W = 48;
    localparam int MB_W   = 24;
    localparam int N_W    = 9;
    localparam int RAD_W  = 56;
    localparam int ROOT_W = RAD_W / 2;
    localparam int DIV_W  = 36;
    localparam int REM_W  = N_W - 1;
    localparam int STEP_W = 6;
    localparam int RCNT_W = 5;
    localparam int TOFF_SH = 27;

    localparam logic [N_W-1:0]    WIN_N = N_W'(WINDOW);
    localparam logic [DIV_W-1:0]  T_OFF = DIV_W'(WINDOW) << TOFF_SH;

    localparam logic [STEP_W-1:0] SQ_STEPS  = STEP_W'(ABS_W);
    localparam logic [STEP_W-1:0] MAG_STEPS = STEP_W'(MAG_W);
    localparam logic [STEP_W-1:0] NSQ_STEPS = STEP_W'(N_W);
    localparam logic [STEP_W-1:0] SSQ_STEPS = STEP_W'(SUM_W);
    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(DIV_W);

    localparam logic REG_LABEL = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_RSTART,
        ST_ROOT,
        ST_MSQ,
        ST_NSQ,
        ST_SSQ,
        ST_DSTD,
        ST_DMEAN,
        ST_DTEMP,
        ST_OUT
    } state_t;

    function automatic logic [ABS_W-1:0] abs_val(input logic signed [IN_W-1:0] v);
        logic [ABS_W-1:0] e;
        e = {v[IN_W-1], v};
        abs_val = v[IN_W-1] ? (~e + ABS_W'(1)) : e;
    endfunction

endpackage

### rtl/mwfe_isqrt.sv
// Floored integer square root, two radicand bits per cycle.
module mwfe_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mwfe_pkg::RAD_W-1:0]    rad,
    output logic                          busy,
    output logic [mwfe_pkg::ROOT_W-1:0]   root
);
    import mwfe_pkg::*;

    logic                busy_reg;
    logic [RCNT_W-1:0]   cnt_reg;
    logic [RAD_W-1:0]    n_reg;
    logic [ROOT_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;
    logic [ROOT_W+1:0]   diff;
    logic                take;

    assign rem_sh = {rem_reg, n_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign take   = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= RCNT_W'(ROOT_W - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - RCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg    <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            n_reg    <= n_reg << 2;
            rem_reg  <= take ? diff[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

### rtl/motion_window_feature_extractor.sv
// Per sample, a 1-bit-per-cycle shift-add multiplier forms each square and the
// 2-bit-per-cycle root unit the magnitude. The sample that closes a window of
// WINDOW samples goes on to further work, in the same multiplier, the root unit
// and a 1-bit-per-cycle divider by WINDOW. One sample is in work at a time; a result waits
// in the output register while the next sample is taken.
module motion_window_feature_extractor (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [mwfe_pkg::IN_W-1:0]   s_accel_x,
    input  logic signed [mwfe_pkg::IN_W-1:0]   s_accel_y,
    input  logic signed [mwfe_pkg::IN_W-1:0]   s_accel_z,
    input  logic signed [mwfe_pkg::IN_W-1:0]   s_gyro_x,
    input  logic signed [mwfe_pkg::IN_W-1:0]   s_gyro_y,
    input  logic signed [mwfe_pkg::IN_W-1:0]   s_gyro_z,
    input  logic signed [mwfe_pkg::IN_W-1:0]   s_temperature,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mwfe_pkg::OUT_W-1:0]         m_accel_mean,
    output logic [mwfe_pkg::OUT_W-1:0]         m_accel_std,
    output logic [mwfe_pkg::OUT_W-1:0]         m_gyro_mean,
    output logic [mwfe_pkg::OUT_W-1:0]         m_gyro_std,
    output logic signed [mwfe_pkg::OUT_W-1:0]  m_temp_mean,
    output logic [mwfe_pkg::LBL_W-1:0]         m_label_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mwfe_pkg::ADDR_W-1:0]        paddr,
    input  logic [mwfe_pkg::DATA_W-1:0]        pwdata,
    output logic [mwfe_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import mwfe_pkg::*;

    state_t state_reg, state_next;

    logic [LBL_W-1:0]         label_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [SUM_W-1:0]         asum_reg, gsum_reg;
    logic [SQS_W-1:0]         asq_reg, gsq_reg;
    logic signed [TSUM_W-1:0] tsum_reg;
    logic                     m_valid_reg;

    logic signed [IN_W-1:0]   smp_reg [0:6];
    logic [1:0]               axis_reg;
    logic                     triad_reg;
    logic                     end_reg;
    logic [PROD_W-1:0]        ma_reg, macc_reg, dd_reg;
    logic [MB_W-1:0]          mb_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [DIV_W-1:0]         dv_reg;
    logic [REM_W-1:0]         drem_reg;
    logic [OUT_W-1:0]         mean_res [0:1];
    logic [OUT_W-1:0]         std_res [0:1];
    logic [OUT_W-1:0]         tmean_res;
    logic [OUT_W-1:0]         am_reg, as_reg, gm_reg, gs_reg, tm_reg;
    logic [LBL_W-1:0]         lo_reg;

    logic                     step_done, last, out_free, cfg_wr, sq_start, sq_busy;
    logic [ROOT_W-1:0]        sq_root;
    logic [RAD_W-1:0]         sq_rad;
    logic [2:0]               sq_idx, sq_idx_nx;
    logic [ABS_W-1:0]         abs_nx;
    logic [N_W-1:0]           div_rs, div_diff;
    logic                     div_ge;
    logic [SUM_W-1:0]         sum_sel;
    logic signed [DIV_W:0]    tnum;

    assign step_done = step_reg == '0;
    assign last      = cnt_reg == CNT_W'(WINDOW - 1);
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == REG_LABEL);
    assign sq_idx    = (triad_reg ? 3'd3 : 3'd0) + {1'b0, axis_reg};
    assign sq_idx_nx = sq_idx + 3'd1;
    assign abs_nx    = abs_val(smp_reg[sq_idx_nx]);
    assign sq_rad    = end_reg ? {dd_reg, 8'h00} : RAD_W'(macc_reg);
    assign div_rs    = {drem_reg, dv_reg[DIV_W-1]};
    assign div_ge    = div_rs >= WIN_N;
    assign div_diff  = div_rs - WIN_N;
    assign sum_sel   = triad_reg ? gsum_reg : asum_reg;
    assign tnum      = ((DIV_W+1)'(tsum_reg) <<< 4) + $signed({1'b0, T_OFF});

    mwfe_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .rad     (sq_rad),
        .busy    (sq_busy),
        .root    (sq_root)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_SQ;
            ST_SQ:     if (step_done && axis_reg == 2'd2) state_next = ST_RSTART;
            ST_RSTART: state_next = ST_ROOT;
            ST_ROOT:   if (!sq_busy) state_next = end_reg ? ST_DSTD : ST_MSQ;
            ST_MSQ: begin
                if (step_done) begin
                    state_next = !triad_reg ? ST_SQ : (last ? ST_NSQ : ST_IDLE);
                end
            end
            ST_NSQ:    if (step_done) state_next = ST_SSQ;
            ST_SSQ:    if (step_done) state_next = ST_RSTART;
            ST_DSTD:   if (step_done) state_next = ST_DMEAN;
            ST_DMEAN:  if (step_done) state_next = triad_reg ? ST_DTEMP : ST_NSQ;
            ST_DTEMP:  if (step_done) state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = state_reg == ST_IDLE;
        sq_start = state_reg == ST_RSTART;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            label_reg   <= '0;
            cnt_reg     <= '0;
            asum_reg    <= '0;
            gsum_reg    <= '0;
            asq_reg     <= '0;
            gsq_reg     <= '0;
            tsum_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                label_reg <= pwdata[LBL_W-1:0];
            end
            if (state_reg == ST_MSQ && step_done) begin
                if (!triad_reg) begin
                    asum_reg <= asum_reg + SUM_W'(mag_reg);
                    asq_reg  <= asq_reg + macc_reg[SQS_W-1:0];
                end else begin
                    gsum_reg <= gsum_reg + SUM_W'(mag_reg);
                    gsq_reg  <= gsq_reg + macc_reg[SQS_W-1:0];
                    tsum_reg <= tsum_reg + TSUM_W'(smp_reg[6]);
                    if (!last) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
                cnt_reg     <= '0;
                asum_reg    <= '0;
                gsum_reg    <= '0;
                asq_reg     <= '0;
                gsq_reg     <= '0;
                tsum_reg    <= '0;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    smp_reg[0] <= s_accel_x;
                    smp_reg[1] <= s_accel_y;
                    smp_reg[2] <= s_accel_z;
                    smp_reg[3] <= s_gyro_x;
                    smp_reg[4] <= s_gyro_y;
                    smp_reg[5] <= s_gyro_z;
                    smp_reg[6] <= s_temperature;
                    axis_reg   <= 2'd0;
                    triad_reg  <= 1'b0;
                    end_reg    <= 1'b0;
                    macc_reg   <= '0;
                    ma_reg     <= PROD_W'(abs_val(s_accel_x));
                    mb_reg     <= MB_W'(abs_val(s_accel_x));
                    step_reg   <= SQ_STEPS;
                end
            end
            ST_SQ, ST_MSQ, ST_NSQ, ST_SSQ: begin
                if (!step_done) begin
                    if (mb_reg[0]) begin
                        macc_reg <= macc_reg + ma_reg;
                    end
                    ma_reg   <= ma_reg << 1;
                    mb_reg   <= mb_reg >> 1;
                    step_reg <= step_reg - STEP_W'(1);
                end else begin
                    case (state_reg)
                        ST_SQ: begin
                            if (axis_reg != 2'd2) begin
                                axis_reg <= axis_reg + 2'd1;
                                ma_reg   <= PROD_W'(abs_nx);
                                mb_reg   <= MB_W'(abs_nx);
                                step_reg <= SQ_STEPS;
                            end
                        end
                        ST_MSQ: begin
                            if (!triad_reg) begin
                                triad_reg <= 1'b1;
                                axis_reg  <= 2'd0;
                                macc_reg  <= '0;
                                ma_reg    <= PROD_W'(abs_val(smp_reg[3]));
                                mb_reg    <= MB_W'(abs_val(smp_reg[3]));
                                step_reg  <= SQ_STEPS;
                            end else if (last) begin
                                triad_reg <= 1'b0;
                                end_reg   <= 1'b1;
                                macc_reg  <= '0;
                                ma_reg    <= PROD_W'(asq_reg);
                                mb_reg    <= MB_W'(WIN_N);
                                step_reg  <= NSQ_STEPS;
                            end
                        end
                        ST_NSQ: begin
                            dd_reg   <= macc_reg;
                            macc_reg <= '0;
                            ma_reg   <= PROD_W'(sum_sel);
                            mb_reg   <= sum_sel;
                            step_reg <= SSQ_STEPS;
                        end
                        default: begin
                            dd_reg <= (dd_reg > macc_reg) ? dd_reg - macc_reg : '0;
                        end
                    endcase
                end
            end
            ST_ROOT: begin
                if (!sq_busy) begin
                    if (!end_reg) begin
                        mag_reg  <= sq_root[MAG_W-1:0];
                        ma_reg   <= PROD_W'(sq_root[MAG_W-1:0]);
                        mb_reg   <= MB_W'(sq_root[MAG_W-1:0]);
                        macc_reg <= '0;
                        step_reg <= MAG_STEPS;
                    end else begin
                        dv_reg   <= DIV_W'(sq_root);
                        drem_reg <= '0;
                        step_reg <= DIV_STEPS;
                    end
                end
            end
            ST_DSTD, ST_DMEAN, ST_DTEMP: begin
                if (!step_done) begin
                    drem_reg <= div_ge ? div_diff[REM_W-1:0] : div_rs[REM_W-1:0];
                    dv_reg   <= {dv_reg[DIV_W-2:0], div_ge};
                    step_reg <= step_reg - STEP_W'(1);
                end else begin
                    case (state_reg)
                        ST_DSTD: begin
                            std_res[triad_reg] <= dv_reg[OUT_W-1:0];
                            dv_reg   <= DIV_W'({sum_sel, 4'h0});
                            drem_reg <= '0;
                            step_reg <= DIV_STEPS;
                        end
                        ST_DMEAN: begin
                            mean_res[triad_reg] <= dv_reg[OUT_W-1:0];
                            if (!triad_reg) begin
                                triad_reg <= 1'b1;
                                macc_reg  <= '0;
                                ma_reg    <= PROD_W'(gsq_reg);
                                mb_reg    <= MB_W'(WIN_N);
                                step_reg  <= NSQ_STEPS;
                            end else begin
                                dv_reg   <= tnum[DIV_W-1:0];
                                drem_reg <= '0;
                                step_reg <= DIV_STEPS;
                            end
                        end
                        default: begin
                            tmean_res <= dv_reg[OUT_W-1:0];
                        end
                    endcase
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    am_reg <= mean_res[0];
                    as_reg <= std_res[0];
                    gm_reg <= mean_res[1];
                    gs_reg <= std_res[1];
                    tm_reg <= tmean_res;
                    lo_reg <= label_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_accel_mean = am_reg;
    assign m_accel_std  = as_reg;
    assign m_gyro_mean  = gm_reg;
    assign m_gyro_std   = gs_reg;
    assign m_temp_mean  = $signed(tm_reg);
    assign m_label_out  = lo_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == REG_LABEL) ? DATA_W'(label_reg) : '0;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(WINDOW - 1))
        else $error("sample count past window end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        sq_start |-> !sq_busy)
        else $error("root unit started while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("window result not presented");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SQ && axis_reg == 2'd0 && !triad_reg))
        else $error("accepted request did not start squaring");

endmodule
